// ----- hw/rtl/dbc_pkg.sv -----
// ----------------------------------------------------------------------------
// dbc_pkg: shared types and constants for the delimiter balance checker
// bracket kinds, status codes, character codes and the queue word layout
// ----------------------------------------------------------------------------
`default_nettype none

package dbc_pkg;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 2;
   localparam int STATUS_W = 3;
   localparam int LINE_W = 16;

   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAREN   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BRACKET = 2'd2;
   localparam logic [KIND_W-1:0] KIND_BRACE   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_CLEAN    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_OPEN  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNCLOSED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TOO_DEEP = 3'd4;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE  = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_SLASH    = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_STAR     = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_LPAREN   = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_RPAREN   = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [CHAR_W-1:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [CHAR_W-1:0] CHAR_LBRACE   = 8'h7B;
   localparam logic [CHAR_W-1:0] CHAR_RBRACE   = 8'h7D;

   localparam logic [LINE_W-1:0] LINE_FIRST = 16'd1;
   localparam logic [LINE_W-1:0] LINE_MAX   = 16'hFFFF;

   localparam int RSP_DATA_W = 24;

   // classified byte handed from front to back
   typedef struct packed {
      logic [KIND_W-1:0] opener;
      logic [KIND_W-1:0] closer;
      logic [LINE_W-1:0] line_pre;   // line of the byte itself
      logic [LINE_W-1:0] line_post;  // line after the byte
      logic              eof;
   } item_type;

   // queue handshake toward the back end
   typedef struct packed {
      logic valid;
      logic ready;
   } queue_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/delimiter_balance_checker_top.sv -----
// an accepted word waits in the queue, and any result word it gives is registered at the output
// throughput: one word per cycle unless a result stalls; the stack engine does one push
// or pop a cycle, top of stack in a register, next entry prefetched from ram
// reset: synchronous, active high; clears the comment flags, the line counter,
// the stack count and the queue; the stack ram is not cleared and needs no sweep
// ----------------------------------------------------------------------------
// delimiter_balance_checker_top: bracket nesting checker for a byte stream
// classifier front end, two-entry queue, stack engine back end
// ----------------------------------------------------------------------------
`default_nettype none

module delimiter_balance_checker_top #(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream: one source byte per word
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] character
   input  wire logic        req_tlast,   // end_of_file
   // response stream: at most one result word per request word
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // [2:0] status, [4:3] expected_kind,
                                         // [6:5] found_kind, [22:7] line_number,
                                         // [23] zero
);

   logic                       req_accept;
   dbc_pkg::item_type          front_item;
   dbc_pkg::item_type          queue_item;
   dbc_pkg::queue_status_type  queue_status;
   logic                       queue_pop;

   // front end takes a word whenever the queue has room
   assign req_tready = queue_status.ready;
   assign req_accept = req_tvalid && req_tready;

   // comment tracking and line counting
   dbc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .character   (req_tdata),
      .end_of_file (req_tlast),
      .item        (front_item)
   );

   // decouples the front end from result back pressure
   dbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_item (front_item),
      .pop       (queue_pop),
      .pop_item  (queue_item),
      .status    (queue_status)
   );

   // stack engine drains the queue while the result register has room
   dbc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_status.valid),
      .item       (queue_item),
      .item_pop   (queue_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   // an accepted word is always waiting in the queue on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> queue_status.valid)
      else $error("accepted word missing from queue");

   // queue never both empty and full
   assert property (@(posedge clock) disable iff (reset)
      queue_status.valid || queue_status.ready)
      else $error("queue flags inconsistent");

   // no result right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result after reset");

   // nothing can pop the queue while a result is stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !queue_pop)
      else $error("queue popped under back pressure");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/dbc_ram.sv -----
// ----------------------------------------------------------------------------
// dbc_ram: generic single-write, single-read ram
// one write port and one read port with registered read data (old data on
// a same-address collision)
// ----------------------------------------------------------------------------
`default_nettype none

module dbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/dbc_front.sv -----
// ----------------------------------------------------------------------------
// dbc_front: byte classifier
// tracks comments and the line counter, turns each byte into an opener or
// closer kind tagged with its line
// ----------------------------------------------------------------------------
`default_nettype none

module dbc_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [dbc_pkg::CHAR_W-1:0]  character,
   input  wire logic                        end_of_file,
   output dbc_pkg::item_type                item
);

   logic                        in_line_ff, in_line_in;
   logic                        in_block_ff, in_block_in;
   logic                        prev_slash_ff, prev_slash_in;
   logic                        prev_star_ff, prev_star_in;
   logic [dbc_pkg::LINE_W-1:0]  line_ff, line_in;
   logic [dbc_pkg::KIND_W-1:0]  opener, closer;
   logic [dbc_pkg::LINE_W-1:0]  line_post;

   always_comb begin
      opener        = dbc_pkg::KIND_NONE;
      closer        = dbc_pkg::KIND_NONE;
      in_line_in    = in_line_ff;
      in_block_in   = in_block_ff;
      prev_slash_in = prev_slash_ff;
      prev_star_in  = prev_star_ff;
      if (in_line_ff) begin
         if (character == dbc_pkg::CHAR_NEWLINE) begin
            in_line_in = 1'b0;
         end
      end else if (in_block_ff) begin
         if (prev_star_ff && character == dbc_pkg::CHAR_SLASH) begin
            in_block_in = 1'b0;
         end
         prev_star_in = (character == dbc_pkg::CHAR_STAR);
      end else if (prev_slash_ff && character == dbc_pkg::CHAR_SLASH) begin
         in_line_in    = 1'b1;
         prev_slash_in = 1'b0;
      end else if (prev_slash_ff && character == dbc_pkg::CHAR_STAR) begin
         in_block_in   = 1'b1;
         prev_star_in  = 1'b0;
         prev_slash_in = 1'b0;
      end else begin
         prev_slash_in = (character == dbc_pkg::CHAR_SLASH);
         unique case (character)
            dbc_pkg::CHAR_LPAREN:   opener = dbc_pkg::KIND_PAREN;
            dbc_pkg::CHAR_LBRACKET: opener = dbc_pkg::KIND_BRACKET;
            dbc_pkg::CHAR_LBRACE:   opener = dbc_pkg::KIND_BRACE;
            dbc_pkg::CHAR_RPAREN:   closer = dbc_pkg::KIND_PAREN;
            dbc_pkg::CHAR_RBRACKET: closer = dbc_pkg::KIND_BRACKET;
            dbc_pkg::CHAR_RBRACE:   closer = dbc_pkg::KIND_BRACE;
            default: ;
         endcase
      end

      // saturating line advance
      if (character == dbc_pkg::CHAR_NEWLINE && line_ff != dbc_pkg::LINE_MAX) begin
         line_post = line_ff + dbc_pkg::LINE_W'(1);
      end else begin
         line_post = line_ff;
      end
      line_in = line_post;

      // end of file starts the next file from scratch
      if (end_of_file) begin
         in_line_in    = 1'b0;
         in_block_in   = 1'b0;
         prev_slash_in = 1'b0;
         prev_star_in  = 1'b0;
         line_in       = dbc_pkg::LINE_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_line_ff    <= 1'b0;
         in_block_ff   <= 1'b0;
         prev_slash_ff <= 1'b0;
         prev_star_ff  <= 1'b0;
         line_ff       <= dbc_pkg::LINE_FIRST;
      end else if (accept) begin
         in_line_ff    <= in_line_in;
         in_block_ff   <= in_block_in;
         prev_slash_ff <= prev_slash_in;
         prev_star_ff  <= prev_star_in;
         line_ff       <= line_in;
      end
   end

   assign item.opener    = opener;
   assign item.closer    = closer;
   assign item.line_pre  = line_ff;
   assign item.line_post = line_post;
   assign item.eof       = end_of_file;

endmodule

`default_nettype wire

// ----- hw/rtl/dbc_queue.sv -----
// ----------------------------------------------------------------------------
// dbc_queue: two-entry queue between classifier and stack engine
// registered full and empty flags, push and pop in the same cycle allowed
// ----------------------------------------------------------------------------
`default_nettype none

module dbc_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  dbc_pkg::item_type          push_item,
   input  wire logic                  pop,
   output dbc_pkg::item_type          pop_item,
   output dbc_pkg::queue_status_type  status
);

   dbc_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = entry_ff[rd_ptr_ff];
   assign status.valid = (count_ff != 2'd0);
   assign status.ready = (count_ff != 2'd2);

endmodule

`default_nettype wire

// ----- hw/rtl/dbc_back.sv -----
// ----------------------------------------------------------------------------
// dbc_back: stack engine and result register
// top of stack in a register, lower entries in ram with a prefetched
// second entry, first-error tracking and the final end-of-file check
// ----------------------------------------------------------------------------
`default_nettype none

module dbc_back #(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             item_valid,
   input  dbc_pkg::item_type                     item,
   output logic                                  item_pop,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [dbc_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

   logic [CW-1:0]              count_ff, count_in;
   logic [dbc_pkg::KIND_W-1:0] top_ff, top_in;
   logic                       err_ff, err_in;
   logic                       byp_ff;
   logic [dbc_pkg::KIND_W-1:0] byp_data_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [dbc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                       fire;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [AW-1:0]              rd_addr;
   logic [dbc_pkg::KIND_W-1:0] rd_data;
   logic [dbc_pkg::KIND_W-1:0] below;
   logic [CW-1:0]              count_sub;
   logic                       hit;
   logic                       produce;
   logic [dbc_pkg::STATUS_W-1:0] status;
   logic [dbc_pkg::KIND_W-1:0] expected;
   logic [dbc_pkg::KIND_W-1:0] found;
   logic [dbc_pkg::LINE_W-1:0] line;

   assign fire     = item_valid && (!rsp_valid_ff || rsp_tready);
   assign item_pop = fire;
   assign below    = byp_ff ? byp_data_ff : rd_data;

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      err_in   = err_ff;
      wr_en    = 1'b0;
      hit      = 1'b0;
      produce  = 1'b0;
      status   = dbc_pkg::STATUS_CLEAN;
      expected = dbc_pkg::KIND_NONE;
      found    = dbc_pkg::KIND_NONE;
      line     = '0;
      if (fire) begin
         if (!err_ff) begin
            if (item.opener != dbc_pkg::KIND_NONE) begin
               if (count_ff == FULL_COUNT) begin
                  hit      = 1'b1;
                  status   = dbc_pkg::STATUS_TOO_DEEP;
                  expected = top_ff;
                  line     = item.line_pre;
               end else begin
                  wr_en    = (count_ff != '0);
                  top_in   = item.opener;
                  count_in = count_ff + CW'(1);
               end
            end else if (item.closer != dbc_pkg::KIND_NONE) begin
               if (count_ff == '0) begin
                  hit    = 1'b1;
                  status = dbc_pkg::STATUS_NO_OPEN;
                  found  = item.closer;
                  line   = item.line_pre;
               end else if (top_ff == item.closer) begin
                  top_in   = below;
                  count_in = count_ff - CW'(1);
               end else begin
                  hit      = 1'b1;
                  status   = dbc_pkg::STATUS_MISMATCH;
                  expected = top_ff;
                  found    = item.closer;
                  line     = item.line_pre;
               end
            end
            produce = hit;
            err_in  = hit;
            // final check when the last byte raised no error
            if (item.eof && !hit) begin
               produce = 1'b1;
               if (count_in != '0) begin
                  status   = dbc_pkg::STATUS_UNCLOSED;
                  expected = top_in;
                  line     = item.line_post;
               end
            end
         end
         if (item.eof) begin
            count_in = '0;
            err_in   = 1'b0;
         end
      end
   end

   // keep the entry just below the top prefetched for the next pop
   assign count_sub = count_in - CW'(2);
   assign rd_addr   = (count_in >= CW'(2)) ? count_sub[AW-1:0] : '0;
   // on a push the old top lands in its own slot, one below the new top
   assign wr_addr   = AW'(count_ff - CW'(1));

   dbc_ram #(
      .WIDTH (dbc_pkg::KIND_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (top_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (produce) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, line, found, expected, status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         err_ff       <= 1'b0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         err_ff       <= err_in;
         byp_ff       <= wr_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      byp_data_ff <= top_ff;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- tb/sv/delimiter_balance_checker_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimiter_balance_checker_top_tb: self-checking bench for the bracket checker
// streams source text through the checker and compares every verdict word
// against a bracket tracker kept alongside, with random gaps and stalls
// ----------------------------------------------------------------------------

module delimiter_balance_checker_top_tb;
   import dbc_pkg::*;

   localparam int STACK_LIMIT = 64;
   localparam int IDLE_LIMIT = 4000;
   localparam int RANDOM_WORDS = 1250;
   localparam int RANDOM_FILES = 40;
   localparam int REPORT_LIMIT = 20;

   // one verdict word, unpacked into its fields
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [KIND_W-1:0]   expected_kind;
      logic [KIND_W-1:0]   found_kind;
      logic [LINE_W-1:0]   line_number;
   } verdict_t;

   // receiver stall patterns
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_EVERY_FOURTH,
      READY_MOSTLY
   } ready_mode_t;

   // tracks bracket nesting per file and keeps the verdicts still to come
   class bracket_tracker;
      logic [KIND_W-1:0] open_kinds [];
      int unsigned       capacity;
      int unsigned       depth;
      logic [LINE_W-1:0] cur_line;
      bit                in_line_comment;
      bit                in_block_comment;
      bit                prev_slash;
      bit                prev_star;
      bit                error_seen;
      verdict_t          awaited_verdicts [$];
      int unsigned       failures;

      function new(int unsigned cap);
         capacity = cap;
         open_kinds = new[cap];
         failures = 0;
         restart();
      endfunction

      function void restart();
         depth = 0;
         cur_line = LINE_FIRST;
         in_line_comment = 0;
         in_block_comment = 0;
         prev_slash = 0;
         prev_star = 0;
         error_seen = 0;
      endfunction

      function logic [KIND_W-1:0] top_kind();
         return (depth == 0) ? KIND_NONE : open_kinds[depth-1];
      endfunction

      function verdict_t make_verdict(logic [STATUS_W-1:0] status, logic [KIND_W-1:0] exp_kind,
                                      logic [KIND_W-1:0] fnd_kind, logic [LINE_W-1:0] line_no);
         verdict_t v;
         v.status = status;
         v.expected_kind = exp_kind;
         v.found_kind = fnd_kind;
         v.line_number = line_no;
         return v;
      endfunction

      // one accepted request word: byte plus end-of-file flag
      function void note_byte(logic [CHAR_W-1:0] c, logic eof);
         logic [KIND_W-1:0] opener;
         logic [KIND_W-1:0] closer;
         verdict_t          v;
         bit                hit;
         opener = KIND_NONE;
         closer = KIND_NONE;
         hit = 0;
         v = '0;
         if (!error_seen) begin
            if (in_line_comment) begin
               if (c == CHAR_NEWLINE) in_line_comment = 0;
            end else if (in_block_comment) begin
               if (prev_star && c == CHAR_SLASH) in_block_comment = 0;
               prev_star = (c == CHAR_STAR);
            end else if (prev_slash && c == CHAR_SLASH) begin
               in_line_comment = 1;
               prev_slash = 0;
            end else if (prev_slash && c == CHAR_STAR) begin
               in_block_comment = 1;
               prev_star = 0;
               prev_slash = 0;
            end else begin
               prev_slash = (c == CHAR_SLASH);
               case (c)
                  CHAR_LPAREN:   opener = KIND_PAREN;
                  CHAR_LBRACKET: opener = KIND_BRACKET;
                  CHAR_LBRACE:   opener = KIND_BRACE;
                  CHAR_RPAREN:   closer = KIND_PAREN;
                  CHAR_RBRACKET: closer = KIND_BRACKET;
                  CHAR_RBRACE:   closer = KIND_BRACE;
                  default: ;
               endcase
               if (opener != KIND_NONE) begin
                  if (depth >= capacity) begin
                     v = make_verdict(STATUS_TOO_DEEP, top_kind(), KIND_NONE, cur_line);
                     hit = 1;
                  end else begin
                     open_kinds[depth] = opener;
                     depth++;
                  end
               end else if (closer != KIND_NONE) begin
                  if (depth == 0) begin
                     v = make_verdict(STATUS_NO_OPEN, KIND_NONE, closer, cur_line);
                     hit = 1;
                  end else if (top_kind() == closer) begin
                     depth--;
                  end else begin
                     v = make_verdict(STATUS_MISMATCH, top_kind(), closer, cur_line);
                     hit = 1;
                  end
               end
            end
            if (c == CHAR_NEWLINE && cur_line != LINE_MAX) cur_line++;
            if (hit) begin
               error_seen = 1;
               awaited_verdicts.push_back(v);
            end
         end
         if (eof) begin
            if (!error_seen) begin
               if (depth != 0)
                  awaited_verdicts.push_back(make_verdict(STATUS_UNCLOSED, top_kind(),
                                                          KIND_NONE, cur_line));
               else
                  awaited_verdicts.push_back(make_verdict(STATUS_CLEAN, KIND_NONE,
                                                          KIND_NONE, '0));
            end
            restart();
         end
      endfunction

      function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
         if (exp_val != act_val) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
         end
      endfunction

      // one accepted response word
      function void check_verdict(logic [23:0] word);
         verdict_t e;
         if (awaited_verdicts.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: verdict expected none actual %h", $time, word);
            return;
         end
         e = awaited_verdicts.pop_front();
         compare_field("status", 32'(e.status), 32'(word[2:0]));
         compare_field("expected_kind", 32'(e.expected_kind), 32'(word[4:3]));
         compare_field("found_kind", 32'(e.found_kind), 32'(word[6:5]));
         compare_field("line_number", 32'(e.line_number), 32'(word[22:7]));
      endfunction

      function int unsigned waiting();
         return awaited_verdicts.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] character
   logic        req_tlast = 1'b0; // end_of_file
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [2:0] status, [4:3] expected_kind,
                                  // [6:5] found_kind, [22:7] line_number

   bracket_tracker tracker;

   // text of the file about to be streamed, last byte carries tlast
   logic [7:0]  text [$];
   int unsigned burst_left = 0;
   int unsigned random_words = 0;
   int unsigned random_files = 0;
   int unsigned idle_cycles = 0;
   ready_mode_t ready_mode = READY_ALWAYS;
   int unsigned mode_left = 0;

   // bytes that steer the checker, plus one plain letter
   logic [7:0] syntax_chars [10] = '{CHAR_LPAREN, CHAR_RPAREN, CHAR_LBRACKET, CHAR_RBRACKET,
                                     CHAR_LBRACE, CHAR_RBRACE, CHAR_SLASH, CHAR_STAR,
                                     CHAR_NEWLINE, 8'h61};

   delimiter_balance_checker_top #(
      .STACK_DEPTH(STACK_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // handshakes are sampled with the values they held at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) tracker.check_verdict(rsp_tdata);
      end
   end

   // receiver: picks a stall pattern at random and switches to another at random
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_t'($urandom_range(0, 3));
         mode_left <= $urandom_range(32, 256);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS:       rsp_tready <= 1'b1;
         READY_COIN:         rsp_tready <= 1'($urandom_range(0, 1));
         READY_EVERY_FOURTH: rsp_tready <= (mode_left[1:0] == 2'd0);
         default:            rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("delimiter_balance_checker_top: mismatch");
            $finish;
         end
      end
   end

   // one request word; bursts of random length separated by random gaps
   task automatic drive_word(logic [7:0] c, logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // now and then a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   // hold off the sender until every outstanding verdict has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.waiting() != 0) @(posedge clock);
   endtask

   task automatic play_text();
      for (int i = 0; i < text.size(); i++) begin
         // rare pause in the middle of a file
         if ($urandom_range(0, 299) == 0) wait_drained();
         drive_word(text[i], i == text.size() - 1);
      end
   endtask

   task automatic play_string(string s);
      text.delete();
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      play_text();
   endtask

   function automatic logic [7:0] opener_char(logic [KIND_W-1:0] kind);
      case (kind)
         KIND_PAREN:   return CHAR_LPAREN;
         KIND_BRACKET: return CHAR_LBRACKET;
         default:      return CHAR_LBRACE;
      endcase
   endfunction

   function automatic logic [7:0] closer_char(logic [KIND_W-1:0] kind);
      case (kind)
         KIND_PAREN:   return CHAR_RPAREN;
         KIND_BRACKET: return CHAR_RBRACKET;
         default:      return CHAR_RBRACE;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] random_kind();
      return KIND_W'($urandom_range(KIND_PAREN, KIND_BRACE));
   endfunction

   function automatic void add_openers(int unsigned count);
      repeat (count) text.push_back(opener_char(random_kind()));
   endfunction

   // builds one random file into text
   function automatic void build_random_file();
      int unsigned       n;
      int unsigned       r;
      logic [KIND_W-1:0] kinds [$];
      logic [KIND_W-1:0] k;
      text.delete();
      if ($urandom_range(0, 14) == 0) begin
         // deep nesting around the stack limit, closed in order
         n = $urandom_range(STACK_LIMIT - 8, STACK_LIMIT + 2);
         repeat (n) begin
            k = random_kind();
            kinds.push_back(k);
            text.push_back(opener_char(k));
         end
         while (kinds.size() > 0) text.push_back(closer_char(kinds.pop_back()));
      end else if ($urandom_range(0, 5) == 0) begin
         // noise: any byte, heavy on the ones that matter
         n = $urandom_range(1, 30);
         repeat (n) begin
            if ($urandom_range(0, 3) == 0) text.push_back(8'($urandom_range(0, 255)));
            else text.push_back(syntax_chars[$urandom_range(0, 9)]);
         end
      end else begin
         // mostly well nested text with comments, newlines and the odd stray closer
         n = $urandom_range(1, 40);
         repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 30 && kinds.size() < 12) begin
               k = random_kind();
               kinds.push_back(k);
               text.push_back(opener_char(k));
            end else if (r < 55 && kinds.size() > 0) begin
               text.push_back(closer_char(kinds.pop_back()));
            end else if (r < 63) begin
               text.push_back(CHAR_NEWLINE);
            end else if (r < 68) begin
               text.push_back(CHAR_SLASH);
               text.push_back(CHAR_SLASH);
               repeat ($urandom_range(0, 5)) text.push_back(syntax_chars[$urandom_range(0, 9)]);
               text.push_back(CHAR_NEWLINE);
            end else if (r < 73) begin
               text.push_back(CHAR_SLASH);
               text.push_back(CHAR_STAR);
               repeat ($urandom_range(0, 6)) text.push_back(syntax_chars[$urandom_range(0, 9)]);
               text.push_back(CHAR_STAR);
               text.push_back(CHAR_SLASH);
            end else if (r < 90) begin
               text.push_back(8'($urandom_range(8'h61, 8'h7A)));
            end else if (r < 96) begin
               text.push_back(8'($urandom_range(0, 255)));
            end else begin
               text.push_back(closer_char(random_kind()));
            end
         end
         // most files close what they opened, some leave it open
         if ($urandom_range(0, 4) != 0)
            while (kinds.size() > 0) text.push_back(closer_char(kinds.pop_back()));
      end
      if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
   endfunction

   initial begin
      tracker = new(STACK_LIMIT);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: clean pair, mismatch on the last byte, closer on line two,
      // unclosed at end, block comment that a slash star slash does not close,
      // line comment up to newline, bytes ignored after an error
      play_string("()");
      play_string("[}");
      play_string("\n)");
      play_string("{\n");
      play_string("/*/(*/]");
      play_string("//[\n)");
      play_string(")(");
      // extremes of the byte value
      text.delete();
      text.push_back(8'h00);
      text.push_back(8'hFF);
      play_text();

      // sender holds off until every verdict is back
      wait_drained();

      // stack filled exactly to the limit and left open at end of file
      text.delete();
      add_openers(STACK_LIMIT);
      text.push_back(CHAR_NEWLINE);
      play_text();
      // one opener past the limit, then more text that must be ignored
      text.delete();
      add_openers(STACK_LIMIT + 1);
      text.push_back(CHAR_RPAREN);
      play_text();

      // random files
      while (random_words < RANDOM_WORDS || random_files < RANDOM_FILES) begin
         build_random_file();
         play_text();
         random_words += text.size();
         random_files++;
         if ($urandom_range(0, 9) == 0) wait_drained();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("delimiter_balance_checker_top: match");
      end else begin
         $display("delimiter_balance_checker_top: mismatch");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/dbc_pkg.sv
hw/rtl/dbc_ram.sv
hw/rtl/dbc_front.sv
hw/rtl/dbc_queue.sv
hw/rtl/dbc_back.sv
hw/rtl/delimiter_balance_checker_top.sv
tb/sv/delimiter_balance_checker_top_tb.sv
